// File: sv/rchit_pkg.sv
// shared types, constants and fixed-point helpers for the ray capsule hit test
`default_nettype none
package rchit_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    // quotient bits of num * 2^FRAC_BITS / den, padded to an even count
    localparam int QW         = 32 + FRAC_BITS;
    localparam int DIV_STAGES = (QW + 1) / 2;
    localparam int NPW        = 2 * DIV_STAGES;
    // squared terms after the fraction shift
    localparam int SQW  = 64 - FRAC_BITS;
    localparam int SUMW = SQW + 2;

    typedef logic signed [31:0] fx_t;
    typedef logic signed [17:0] unit_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [65:0] wide_t;

    localparam wide_t FX_ONE = 66'sd1 <<< FRAC_BITS;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_CENTER_X   = 4'd0,
        REG_CENTER_Y   = 4'd1,
        REG_CENTER_Z   = 4'd2,
        REG_AXIS_X     = 4'd3,
        REG_AXIS_Y     = 4'd4,
        REG_AXIS_Z     = 4'd5,
        REG_SEG_LENGTH = 4'd6,
        REG_SEG_RADIUS = 4'd7
    } cfg_reg_t;

    // data that rides along the divider
    typedef struct packed {
        fx_t [2:0]   o;
        unit_t [2:0] d;
        fx_t [2:0]   p1;
        fx_t         d1d2;
        fx_t         dd1;
        logic        neg;
        logic        par;
    } div_side_t;

    // widen a q value for saturating sums
    function automatic wide_t ext(input fx_t x);
        return wide_t'(x);
    endfunction

    // clamp to 32-bit signed
    function automatic fx_t sat32(input wide_t v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return fx_t'(v[31:0]);
    endfunction

    // full signed product
    function automatic prod_t mul(input fx_t a, input fx_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // floor shift of a product and clamp
    function automatic fx_t fsh(input prod_t p);
        prod_t sh;
        sh = p >>> FRAC_BITS;
        return sat32(wide_t'(sh));
    endfunction

endpackage
`default_nettype wire

// File: sv/rchit_div.sv
// pipelined restoring divider, two quotient bits per stage, with side data
`default_nettype none
module rchit_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [31:0]                  nmag,
    input  wire logic [31:0]                  dmag,
    input  wire rchit_pkg::div_side_t         side_in,
    output logic                              out_valid,
    output logic [rchit_pkg::NPW-1:0]         quot,
    output rchit_pkg::div_side_t              side_out
);

    localparam int NS = rchit_pkg::DIV_STAGES;
    localparam int NW = rchit_pkg::NPW;

    logic                 v_reg    [NS];
    logic [31:0]          rem_reg  [NS];
    logic [NW-1:0]        nsh_reg  [NS];
    logic [NW-1:0]        quo_reg  [NS];
    logic [31:0]          d_reg    [NS];
    rchit_pkg::div_side_t side_reg [NS];

    logic [31:0]          rem_next [NS];
    logic [NW-1:0]        nsh_next [NS];
    logic [NW-1:0]        quo_next [NS];

    // one restoring step: returns {remainder, quotient bit}
    function automatic logic [32:0] step1(input logic [31:0] rem, input logic nb,
                                          input logic [31:0] dv);
        logic [32:0] r;
        logic [32:0] diff;
        r    = {rem, nb};
        diff = r - {1'b0, dv};
        if (r >= {1'b0, dv})
            return {diff[31:0], 1'b1};
        else
            return {r[31:0], 1'b0};
    endfunction

    // two steps per stage
    always_comb
    begin
        logic [31:0]   rp;
        logic [NW-1:0] np;
        logic [NW-1:0] qp;
        logic [31:0]   dp;
        logic [32:0]   s0;
        logic [32:0]   s1;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                rp = '0;
                np = NW'({nmag, {rchit_pkg::FRAC_BITS{1'b0}}});
                qp = '0;
                dp = dmag;
            end
            else
            begin
                rp = rem_reg[k-1];
                np = nsh_reg[k-1];
                qp = quo_reg[k-1];
                dp = d_reg[k-1];
            end
            s0 = step1(rp, np[NW-1], dp);
            s1 = step1(s0[32:1], np[NW-2], dp);
            rem_next[k] = s1[32:1];
            nsh_next[k] = np << 2;
            quo_next[k] = {qp[NW-3:0], s0[0], s1[0]};
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nsh_reg[k] <= nsh_next[k];
                quo_reg[k] <= quo_next[k];
            end
            d_reg[0]    <= dmag;
            side_reg[0] <= side_in;
            for (int k = 1; k < NS; k++)
            begin
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign quot      = quo_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
`default_nettype wire

// File: sv/ray_capsule_hit_test_top.sv
// ray versus capsule segment hit test, fully pipelined top level
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in       | in_valid/in_ready    | origin_x/y/z, dir_x/y/z
//  out      | out_valid/out_ready  | is_hit, is_parallel
//
// one ray beat per cycle unless a stalled output beat holds the pipeline;
// s is formed in Q16.16 by the 2-bit-per-stage divider.
// reset clears all valid bits and loads the default segment.
// a stalled output beat freezes the whole pipeline; nothing is dropped or repeated.
// cfg_ready is always high; the user must write registers only while no ray is in flight (not enforced here).
`default_nettype none
module ray_capsule_hit_test_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_y,
    input  wire logic signed [31:0] origin_z,
    input  wire logic signed [17:0] dir_x,
    input  wire logic signed [17:0] dir_y,
    input  wire logic signed [17:0] dir_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    is_hit,
    output logic                    is_parallel
);

    localparam int FB = rchit_pkg::FRAC_BITS;
    localparam int NW = rchit_pkg::NPW;
    localparam int SU = rchit_pkg::SUMW;

    // configuration registers
    rchit_pkg::fx_t   center_reg [3];
    rchit_pkg::unit_t axis_reg   [3];
    logic [30:0]      seg_length_reg;
    logic [30:0]      seg_radius_reg;
    logic [61:0]      rad_sq_reg;

    logic en;

    // pre-divider stages
    logic              v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    rchit_pkg::fx_t    o0_reg [3], o1_reg [3], o2_reg [3], o3_reg [3];
    rchit_pkg::fx_t    o4_reg [3], o5_reg [3], o6_reg [3], o7_reg [3];
    rchit_pkg::unit_t  d0_reg [3], d1_reg [3], d2_reg [3], d3_reg [3];
    rchit_pkg::unit_t  d4_reg [3], d5_reg [3], d6_reg [3], d7_reg [3];
    rchit_pkg::prod_t  ha1_reg [3], ad1_reg [3];
    rchit_pkg::fx_t    p1_2_reg [3], p1_3_reg [3], p1_4_reg [3];
    rchit_pkg::fx_t    p1_5_reg [3], p1_6_reg [3], p1_7_reg [3];
    rchit_pkg::fx_t    d1d2_2_reg, d1d2_3_reg, d1d2_4_reg, d1d2_5_reg, d1d2_6_reg, d1d2_7_reg;
    rchit_pkg::fx_t    dl3_reg [3];
    rchit_pkg::prod_t  dsq3_reg;
    rchit_pkg::prod_t  pa4_reg [3], pd4_reg [3];
    rchit_pkg::fx_t    den4_reg, den5_reg, den6_reg, den7_reg;
    rchit_pkg::fx_t    dd1_5_reg, dd1_6_reg, dd1_7_reg;
    rchit_pkg::fx_t    dd2_5_reg, dd2_6_reg;
    rchit_pkg::prod_t  n6_reg;
    rchit_pkg::fx_t    num7_reg;

    // divider hookup
    logic [31:0]          nmag;
    logic [31:0]          dmag;
    rchit_pkg::div_side_t side_in;
    logic                 div_valid;
    logic [NW-1:0]        quot;
    rchit_pkg::div_side_t side_out;

    // post-divider stages
    logic                 w0_reg, w1_reg, w2_reg, w3_reg, w4_reg, w5_reg, w6_reg;
    rchit_pkg::fx_t       s0_next;
    rchit_pkg::fx_t       s0_reg;
    rchit_pkg::div_side_t sd0_reg, sd1_reg;
    rchit_pkg::prod_t     st1_reg;
    rchit_pkg::prod_t     sdp1_reg [3];
    rchit_pkg::fx_t       t2_reg, t3_reg;
    rchit_pkg::fx_t       q2_2_reg [3], q2_3_reg [3];
    rchit_pkg::fx_t       p1_p2_reg [3], p1_p3_reg [3];
    logic                 par2_reg, par3_reg, par4_reg, par5_reg, par6_reg;
    logic                 miss4_reg, miss5_reg, miss6_reg;
    rchit_pkg::prod_t     ta3_reg [3];
    rchit_pkg::fx_t       df4_reg [3];
    logic [63:0]          sq5_reg [3];
    logic [SU-1:0]        r2_6_reg;
    logic                 hit_reg, parallel_reg, out_valid_reg;

    logic [32:0]          abs_t;
    logic [SU-1:0]        r2_sum;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                center_reg[i] <= '0;
            axis_reg[0]    <= '0;
            axis_reg[1]    <= '0;
            axis_reg[2]    <= 18'sd1 <<< FB;
            seg_length_reg <= 31'd1 << (FB - 1);
            seg_radius_reg <= 31'd1 << (FB - 1);
        end
        else if (cfg_valid)
        begin
            case (rchit_pkg::cfg_reg_t'(cfg_index))
                rchit_pkg::REG_CENTER_X:   center_reg[0]  <= cfg_data;
                rchit_pkg::REG_CENTER_Y:   center_reg[1]  <= cfg_data;
                rchit_pkg::REG_CENTER_Z:   center_reg[2]  <= cfg_data;
                rchit_pkg::REG_AXIS_X:     axis_reg[0]    <= cfg_data[17:0];
                rchit_pkg::REG_AXIS_Y:     axis_reg[1]    <= cfg_data[17:0];
                rchit_pkg::REG_AXIS_Z:     axis_reg[2]    <= cfg_data[17:0];
                rchit_pkg::REG_SEG_LENGTH: seg_length_reg <= cfg_data[30:0];
                rchit_pkg::REG_SEG_RADIUS: seg_radius_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // squared radius follows the radius register
    always_ff @(posedge clk)
    begin
        rad_sq_reg <= 62'(seg_radius_reg) * 62'(seg_radius_reg);
    end

    // valid bits for all stages outside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0; v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0;
            w0_reg <= 1'b0; w1_reg <= 1'b0; w2_reg <= 1'b0; w3_reg <= 1'b0;
            w4_reg <= 1'b0; w5_reg <= 1'b0; w6_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
            w0_reg <= div_valid;
            w1_reg <= w0_reg; w2_reg <= w1_reg; w3_reg <= w2_reg; w4_reg <= w3_reg;
            w5_reg <= w4_reg; w6_reg <= w5_reg;
            out_valid_reg <= w6_reg;
        end
    end

    // pre-divider datapath: endpoint, dot products, numerator, denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // capture the ray beat
            o0_reg[0] <= origin_x; o0_reg[1] <= origin_y; o0_reg[2] <= origin_z;
            d0_reg[0] <= dir_x;    d0_reg[1] <= dir_y;    d0_reg[2] <= dir_z;

            for (int i = 0; i < 3; i++)
            begin
                // half-length times axis, axis times direction
                ha1_reg[i] <= rchit_pkg::mul(rchit_pkg::fx_t'({2'b00, seg_length_reg[30:1]}),
                                             rchit_pkg::fx_t'(axis_reg[i]));
                ad1_reg[i] <= rchit_pkg::mul(rchit_pkg::fx_t'(axis_reg[i]),
                                             rchit_pkg::fx_t'(d0_reg[i]));
                o1_reg[i] <= o0_reg[i]; d1_reg[i] <= d0_reg[i];

                // first endpoint
                p1_2_reg[i] <= rchit_pkg::sat32(rchit_pkg::ext(center_reg[i])
                               - rchit_pkg::ext(rchit_pkg::fsh(ha1_reg[i])));
                o2_reg[i] <= o1_reg[i]; d2_reg[i] <= d1_reg[i];

                // endpoint minus origin
                dl3_reg[i]  <= rchit_pkg::sat32(rchit_pkg::ext(p1_2_reg[i])
                               - rchit_pkg::ext(o2_reg[i]));
                p1_3_reg[i] <= p1_2_reg[i];
                o3_reg[i] <= o2_reg[i]; d3_reg[i] <= d2_reg[i];

                // products for the two remaining dot products
                pa4_reg[i] <= rchit_pkg::mul(dl3_reg[i], rchit_pkg::fx_t'(axis_reg[i]));
                pd4_reg[i] <= rchit_pkg::mul(dl3_reg[i], rchit_pkg::fx_t'(d3_reg[i]));
                p1_4_reg[i] <= p1_3_reg[i];
                o4_reg[i] <= o3_reg[i]; d4_reg[i] <= d3_reg[i];

                p1_5_reg[i] <= p1_4_reg[i]; o5_reg[i] <= o4_reg[i]; d5_reg[i] <= d4_reg[i];
                p1_6_reg[i] <= p1_5_reg[i]; o6_reg[i] <= o5_reg[i]; d6_reg[i] <= d5_reg[i];
                p1_7_reg[i] <= p1_6_reg[i]; o7_reg[i] <= o6_reg[i]; d7_reg[i] <= d6_reg[i];
            end

            // axis dot direction
            d1d2_2_reg <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(ad1_reg[0]))
                          + rchit_pkg::ext(rchit_pkg::fsh(ad1_reg[1]))
                          + rchit_pkg::ext(rchit_pkg::fsh(ad1_reg[2])));
            d1d2_3_reg <= d1d2_2_reg;
            dsq3_reg   <= rchit_pkg::mul(d1d2_2_reg, d1d2_2_reg);

            // denominator
            d1d2_4_reg <= d1d2_3_reg;
            den4_reg   <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(dsq3_reg))
                          - rchit_pkg::FX_ONE);

            // dd1 and dd2
            dd1_5_reg <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(pa4_reg[0]))
                         + rchit_pkg::ext(rchit_pkg::fsh(pa4_reg[1]))
                         + rchit_pkg::ext(rchit_pkg::fsh(pa4_reg[2])));
            dd2_5_reg <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(pd4_reg[0]))
                         + rchit_pkg::ext(rchit_pkg::fsh(pd4_reg[1]))
                         + rchit_pkg::ext(rchit_pkg::fsh(pd4_reg[2])));
            d1d2_5_reg <= d1d2_4_reg;
            den5_reg   <= den4_reg;

            // dd1 times d1d2
            n6_reg     <= rchit_pkg::mul(dd1_5_reg, d1d2_5_reg);
            dd1_6_reg  <= dd1_5_reg;
            dd2_6_reg  <= dd2_5_reg;
            d1d2_6_reg <= d1d2_5_reg;
            den6_reg   <= den5_reg;

            // numerator
            num7_reg   <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(n6_reg))
                          - rchit_pkg::ext(dd2_6_reg));
            dd1_7_reg  <= dd1_6_reg;
            d1d2_7_reg <= d1d2_6_reg;
            den7_reg   <= den6_reg;
        end
    end

    // magnitudes and sign into the divider
    always_comb
    begin
        nmag = num7_reg[31] ? (~num7_reg + 32'd1) : num7_reg;
        dmag = den7_reg[31] ? (~den7_reg + 32'd1) : den7_reg;
        for (int i = 0; i < 3; i++)
        begin
            side_in.o[i]  = o7_reg[i];
            side_in.d[i]  = d7_reg[i];
            side_in.p1[i] = p1_7_reg[i];
        end
        side_in.d1d2 = d1d2_7_reg;
        side_in.dd1  = dd1_7_reg;
        side_in.neg  = num7_reg[31] ^ den7_reg[31];
        side_in.par  = (den7_reg == '0);
    end

    rchit_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .nmag      (nmag),
        .dmag      (dmag),
        .side_in   (side_in),
        .out_valid (div_valid),
        .quot      (quot),
        .side_out  (side_out)
    );

    // signed, saturated ray parameter s
    always_comb
    begin
        if (!side_out.neg)
        begin
            if (quot > NW'(32'h7fffffff))
                s0_next = 32'sh7fffffff;
            else
                s0_next = rchit_pkg::fx_t'(quot[31:0]);
        end
        else
        begin
            if (quot > NW'(33'h080000000))
                s0_next = 32'sh80000000;
            else
                s0_next = rchit_pkg::fx_t'(~quot[31:0] + 32'd1);
        end
    end

    // |t| for the range check
    assign abs_t = t3_reg[31] ? (33'd0 - 33'(t3_reg)) : 33'(t3_reg);

    // squared distance
    assign r2_sum = SU'(sq5_reg[0][63:FB]) + SU'(sq5_reg[1][63:FB]) + SU'(sq5_reg[2][63:FB]);

    // post-divider datapath: t, closest points, distance, compare
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            sd0_reg <= side_out;

            // s times d1d2 and s times direction
            st1_reg <= rchit_pkg::mul(s0_reg, sd0_reg.d1d2);
            for (int i = 0; i < 3; i++)
                sdp1_reg[i] <= rchit_pkg::mul(s0_reg, rchit_pkg::fx_t'(sd0_reg.d[i]));
            sd1_reg <= sd0_reg;

            // t and ray point
            t2_reg <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::fsh(st1_reg))
                      - rchit_pkg::ext(sd1_reg.dd1));
            for (int i = 0; i < 3; i++)
            begin
                q2_2_reg[i]  <= rchit_pkg::sat32(rchit_pkg::ext(sd1_reg.o[i])
                                + rchit_pkg::ext(rchit_pkg::fsh(sdp1_reg[i])));
                p1_p2_reg[i] <= sd1_reg.p1[i];
            end
            par2_reg <= sd1_reg.par;

            // t times axis
            for (int i = 0; i < 3; i++)
            begin
                ta3_reg[i]   <= rchit_pkg::mul(t2_reg, rchit_pkg::fx_t'(axis_reg[i]));
                q2_3_reg[i]  <= q2_2_reg[i];
                p1_p3_reg[i] <= p1_p2_reg[i];
            end
            t3_reg   <= t2_reg;
            par3_reg <= par2_reg;

            // axis point or endpoint, minus ray point
            for (int i = 0; i < 3; i++)
            begin
                if (!t3_reg[31])
                    df4_reg[i] <= rchit_pkg::sat32(rchit_pkg::ext(rchit_pkg::sat32(
                                  rchit_pkg::ext(p1_p3_reg[i])
                                  + rchit_pkg::ext(rchit_pkg::fsh(ta3_reg[i]))))
                                  - rchit_pkg::ext(q2_3_reg[i]));
                else
                    df4_reg[i] <= rchit_pkg::sat32(rchit_pkg::ext(p1_p3_reg[i])
                                  - rchit_pkg::ext(q2_3_reg[i]));
            end
            miss4_reg <= (abs_t > {2'b00, seg_length_reg});
            par4_reg  <= par3_reg;

            // squares
            for (int i = 0; i < 3; i++)
                sq5_reg[i] <= 64'(rchit_pkg::mul(df4_reg[i], df4_reg[i]));
            miss5_reg <= miss4_reg;
            par5_reg  <= par4_reg;

            // summed squares
            r2_6_reg  <= r2_sum;
            miss6_reg <= miss5_reg;
            par6_reg  <= par5_reg;

            // verdict
            parallel_reg <= par6_reg;
            hit_reg      <= !par6_reg && !miss6_reg
                            && (r2_6_reg <= SU'(rad_sq_reg[61:FB]));
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_hit      = hit_reg;
    assign is_parallel = parallel_reg;

endmodule
`default_nettype wire

// File: bench/ray_capsule_hit_test_top_tb.sv
// self-checking testbench for the ray capsule hit test top level
`timescale 1ns / 100ps
`default_nettype none
module ray_capsule_hit_test_top_tb;

    localparam int LATENCY   = 8 + rchit_pkg::DIV_STAGES + 8;
    localparam int N_RANDOM  = 700;
    localparam int CYCLE_MAX = 400000;

    typedef struct {
        logic signed [31:0] ox, oy, oz;
        logic signed [17:0] dx, dy, dz;
    } ray_t;

    typedef struct {
        logic hit;
        logic par;
    } verdict_t;

    // capsule geometry held by the predictor
    typedef struct {
        longint cx, cy, cz;
        longint ax, ay, az;
        longint len, rad;
    } capsule_t;

    // scoreboard: predicts each ray verdict and checks beats in order
    class hit_scoreboard;
        capsule_t cap;
        verdict_t pending[$];
        int       mismatches;
        int       checked;
        int       hits;
        int       parallels;

        function void reset_geometry();
            cap.cx = 0; cap.cy = 0; cap.cz = 0;
            cap.ax = 0; cap.ay = 0; cap.az = 1 << rchit_pkg::FRAC_BITS;
            cap.len = 1 << (rchit_pkg::FRAC_BITS - 1);
            cap.rad = 1 << (rchit_pkg::FRAC_BITS - 1);
        endfunction

        function void write_reg(rchit_pkg::cfg_reg_t idx, logic [31:0] v);
            case (idx)
                rchit_pkg::REG_CENTER_X:   cap.cx = longint'($signed(v));
                rchit_pkg::REG_CENTER_Y:   cap.cy = longint'($signed(v));
                rchit_pkg::REG_CENTER_Z:   cap.cz = longint'($signed(v));
                rchit_pkg::REG_AXIS_X:     cap.ax = longint'($signed(v[17:0]));
                rchit_pkg::REG_AXIS_Y:     cap.ay = longint'($signed(v[17:0]));
                rchit_pkg::REG_AXIS_Z:     cap.az = longint'($signed(v[17:0]));
                rchit_pkg::REG_SEG_LENGTH: cap.len = longint'(v[30:0]);
                rchit_pkg::REG_SEG_RADIUS: cap.rad = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // floored fixed-point product, clamped
        function longint qmul(longint a, longint b);
            return clamp((a * b) >>> rchit_pkg::FRAC_BITS);
        endfunction

        function longint dot(longint u0, longint u1, longint u2,
                             longint v0, longint v1, longint v2);
            return clamp(qmul(u0, v0) + qmul(u1, v1) + qmul(u2, v2));
        endfunction

        function verdict_t predict(ray_t r);
            longint o[3], d[3], a[3], c[3], p1[3], dl[3], q1[3], q2[3], df;
            longint half, d1d2, dd1, dd2, num, den, s, t, abst, r2, rad2;
            verdict_t v;
            o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
            d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
            a[0] = cap.ax; a[1] = cap.ay; a[2] = cap.az;
            c[0] = cap.cx; c[1] = cap.cy; c[2] = cap.cz;
            v.hit = 1'b0;
            v.par = 1'b0;
            half = cap.len >>> 1;
            for (int i = 0; i < 3; i++)
            begin
                p1[i] = clamp(c[i] - qmul(half, a[i]));
                dl[i] = clamp(p1[i] - o[i]);
            end
            d1d2 = dot(a[0], a[1], a[2], d[0], d[1], d[2]);
            dd1  = dot(dl[0], dl[1], dl[2], a[0], a[1], a[2]);
            dd2  = dot(dl[0], dl[1], dl[2], d[0], d[1], d[2]);
            num  = clamp(qmul(dd1, d1d2) - dd2);
            den  = clamp(qmul(d1d2, d1d2) - (64'sd1 << rchit_pkg::FRAC_BITS));
            if (den == 0)
            begin
                v.par = 1'b1;
                return v;
            end
            // signed division truncates toward zero
            s = clamp((num * (64'sd1 << rchit_pkg::FRAC_BITS)) / den);
            t = clamp(qmul(s, d1d2) - dd1);
            abst = (t < 0) ? -t : t;
            if (abst > cap.len)
                return v;
            r2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                q1[i] = clamp(p1[i] + qmul(t, a[i]));
                q2[i] = clamp(o[i] + qmul(s, d[i]));
                df = clamp((t >= 0 ? q1[i] : p1[i]) - q2[i]);
                r2 += (df * df) >>> rchit_pkg::FRAC_BITS;
            end
            rad2 = (cap.rad * cap.rad) >>> rchit_pkg::FRAC_BITS;
            v.hit = (r2 <= rad2);
            return v;
        endfunction

        function void note_ray(ray_t r);
            pending.push_back(predict(r));
        endfunction

        function void check_beat(logic hit, logic par);
            verdict_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: hit=%0b parallel=%0b", hit, par);
                return;
            end
            e = pending.pop_front();
            if (hit) hits++;
            if (par) parallels++;
            if (hit !== e.hit || par !== e.par)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: expected hit=%0b parallel=%0b, got hit=%0b parallel=%0b",
                             checked, e.hit, e.par, hit, par);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [17:0] dir_x, dir_y, dir_z;
    logic               out_valid;
    logic               out_ready;
    logic               is_hit;
    logic               is_parallel;

    hit_scoreboard sb;
    int            cycles = 0;
    int            rays_sent;

    ray_capsule_hit_test_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_hit     (is_hit),
        .is_parallel(is_parallel)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, checks at the rising edge
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_beat(is_hit, is_parallel);
        end
    end

    // one register write beat
    task automatic write_cfg(rchit_pkg::cfg_reg_t idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one ray beat, after a random gap unless no_gap is set; called at a falling edge
    task automatic send_ray(ray_t r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_ray(r);
        rays_sent++;
        @(negedge clk);
    endtask

    // hold off until the pipeline has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic signed [17:0] rand_unit();
        int k;
        k = $urandom_range(0, 5);
        case (k)
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'sd0;
            3: return 18'(($urandom_range(0, 131071)));
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 7);
        case (k)
            0: return 32'($urandom());
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
        endcase
    endfunction

    // random ray, mostly near the origin with a mix of extreme values
    function automatic ray_t rand_ray();
        ray_t r;
        r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
        r.dx = rand_unit(); r.dy = rand_unit(); r.dz = rand_unit();
        return r;
    endfunction

    function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = 18'(dx); r.dy = 18'(dy); r.dz = 18'(dz);
        return r;
    endfunction

    // program a whole capsule setting
    task automatic load_capsule(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                logic [31:0] len, logic [31:0] rad);
        write_cfg(rchit_pkg::REG_CENTER_X, cx);
        write_cfg(rchit_pkg::REG_CENTER_Y, cy);
        write_cfg(rchit_pkg::REG_CENTER_Z, cz);
        write_cfg(rchit_pkg::REG_AXIS_X, ax);
        write_cfg(rchit_pkg::REG_AXIS_Y, ay);
        write_cfg(rchit_pkg::REG_AXIS_Z, az);
        write_cfg(rchit_pkg::REG_SEG_LENGTH, len);
        write_cfg(rchit_pkg::REG_SEG_RADIUS, rad);
    endtask

    // stimulus
    initial
    begin
        ray_t r;
        int   one;
        sb = new();
        sb.reset_geometry();
        rays_sent = 0;
        one = 1 << rchit_pkg::FRAC_BITS;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rays on the reset capsule
        send_ray(mk(0, 0, 0, 0, 0, one), 0);            // parallel to the axis
        send_ray(mk(0, 0, 0, 0, 0, -one), 0);
        send_ray(mk(-one, 0, 0, one, 0, 0), 0);         // straight through
        send_ray(mk(-one, one, 0, one, 0, 0), 0);       // passes wide
        send_ray(mk(-one, 0, 5 * one, one, 0, 0), 0);   // beyond the segment end
        send_ray(mk(-one, 0, -one / 4, one, 0, 0), 0);  // below the center, at the first endpoint, t = 0
        send_ray(mk(-one, one / 2, 0, one, 0, 0), 0);   // exactly at radius
        send_ray(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, one, one, one), 0);
        send_ray(mk(32'h80000000, 32'h80000000, 32'h80000000, -one, -one, -one), 0);
        send_ray(mk(0, 0, 0, 0, 0, 0), 0);              // zero direction
        send_ray(mk(one, -one, 0, 18'h1ffff, 18'h20000, 18'h00001), 0);
        send_ray(mk(-one, 0, 0, one, one, 0), 0);       // non-unit direction
        drain();

        // extreme register values
        load_capsule(32'h7fffffff, 32'h80000000, 32'h0, 32'h3ffff, 32'h20000,
                     32'h1ffff, 32'h7fffffff, 32'h7fffffff);
        send_ray(mk(0, 0, 0, one, 0, 0), 0);
        send_ray(mk(32'h7fffffff, 32'h80000000, 0, 0, one, 0), 0);
        send_ray(mk(-one, 0, 0, 0, 0, one), 0);
        drain();
        load_capsule(0, 0, 0, 0, 0, 0, 0, 0);
        send_ray(mk(0, 0, 0, one, 0, 0), 0);
        send_ray(mk(one, one, one, 0, one, 0), 0);
        drain();

        // random phases with varied capsules; one phase runs back to back
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
                load_capsule(0, 0, 0, 0, 0, one, one / 2, one / 2);
            else
                load_capsule(rand_coord(), rand_coord(), rand_coord(),
                             32'(rand_unit()), 32'(rand_unit()), 32'(rand_unit()),
                             $urandom_range(0, 4) == 0 ? $urandom() & 32'h7fffffff
                                                        : $urandom_range(0, 4 << 16),
                             $urandom_range(0, 4) == 0 ? $urandom() & 32'h7fffffff
                                                        : $urandom_range(0, 3 << 16));
            for (int n = 0; n < N_RANDOM / 7; n++)
            begin
                r = rand_ray();
                send_ray(r, ph == 3);
            end
            drain();
        end

        $display("rays sent: %0d, beats checked: %0d (%0d hits, %0d parallel)",
                 rays_sent, sb.checked, sb.hits, sb.parallels);
        $display("covered reset, extreme and random capsule settings under random stalls");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches, sb.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/rchit_pkg.sv
sv/rchit_div.sv
sv/ray_capsule_hit_test_top.sv
bench/ray_capsule_hit_test_top_tb.sv
